FILE: sv/mode_line_decimal_field_parser_top_assert.svh
// Assertion macros shared by the mode-line parser RTL.
`ifndef MODE_LINE_DECIMAL_FIELD_PARSER_TOP_ASSERT_SVH
`define MODE_LINE_DECIMAL_FIELD_PARSER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked check, off while reset is asserted
`define MLDFP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("mode line parser check failed");
// Clocked check that also holds during reset
`define MLDFP_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("mode line parser check failed");
`else
`define MLDFP_ASSERT(lbl, clk, rst_n, prop)
`define MLDFP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: sv/mldfp_pkg.sv
// Types and constants of the mode-line parser.
package mldfp_pkg;

	localparam int FIELD_W    = 32;
	localparam int OUT_FIELDS = 4;

	// Characters the parser recognizes
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_I     = 8'h49;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Result kinds
	localparam logic KIND_RECORD = 1'b0;
	localparam logic KIND_ERROR  = 1'b1;

	// Position within the current line
	typedef enum logic [4:0] {
		PH_START      = 5'b00001,
		PH_COMMENT    = 5'b00010,
		PH_AFTER_MODE = 5'b00100,
		PH_FIELDS     = 5'b01000,
		PH_SKIP       = 5'b10000
	} phase_t;

	// One result item
	typedef struct packed {
		logic                                kind;
		logic                                mode;
		logic [OUT_FIELDS-1:0][FIELD_W-1:0]  fld;
		logic [FIELD_W-1:0]                  line;
	} rec_t;

endpackage

FILE: sv/mldfp_parser.sv
// Line parser state machine: consumes one byte per cycle while item_valid is high, builds records and errors.
module mldfp_parser #(
	parameter int FIELD_COUNT = 4,
	parameter int MAX_DIGITS  = 10,
	parameter int LINE_BITS   = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	input  logic [7:0]    byte_in,
	input  logic          end_of_input,
	output logic          res_emit,
	output mldfp_pkg::rec_t res
);
	import mldfp_pkg::*;

	localparam int FC_W = $clog2(FIELD_COUNT + 1);
	localparam int DC_W = $clog2(MAX_DIGITS + 1);

	phase_t               phase_q, phase_nxt;
	logic [LINE_BITS-1:0] lc_q, lc_nxt;
	logic                 mode_q, mode_nxt;
	logic [FIELD_W-1:0]   dv_q, dv_nxt;
	logic                 ov_q, ov_nxt;
	logic [DC_W-1:0]      dc_q, dc_nxt;
	logic                 lz_q, lz_nxt;
	logic [FC_W-1:0]      fc_q, fc_nxt;
	logic [FIELD_W-1:0]   store_q [FIELD_COUNT];
	logic                 store_wr;

	logic                 is_space, is_digit;
	logic [FIELD_W+3:0]   acc;
	logic                 acc_over;
	logic                 close_ok;
	logic [FC_W-1:0]      fc_closed;
	logic                 emit, emit_err;
	logic [LINE_BITS-1:0] lc_emit;
	logic [63:0]          lc_wide;
	logic [OUT_FIELDS-1:0][FIELD_W-1:0] rec_fld;

	// Byte classes
	always_comb begin
		is_space = byte_in inside {CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};
		is_digit = byte_in inside {[CH_ZERO:CH_NINE]};
	end

	// Decimal accumulate: value*10 + digit, overflow past 32 bits is sticky
	assign acc      = {1'b0, dv_q, 3'b000} + {3'b000, dv_q, 1'b0}
	                + (FIELD_W+4)'(byte_in[3:0]);
	assign acc_over = ov_q | (|acc[FIELD_W+3:FIELD_W]);

	// Pending field may be stored: in range, no leading zero, room left
	assign close_ok  = !ov_q && !(lz_q && dc_q > DC_W'(1)) && (fc_q < FC_W'(FIELD_COUNT));
	assign fc_closed = (dc_q != '0) ? fc_q + FC_W'(1) : fc_q;

	// Next-state and result decision
	always_comb begin
		phase_nxt = phase_q;
		lc_nxt    = lc_q;
		mode_nxt  = mode_q;
		dv_nxt    = dv_q;
		ov_nxt    = ov_q;
		dc_nxt    = dc_q;
		lz_nxt    = lz_q;
		fc_nxt    = fc_q;
		store_wr  = 1'b0;
		emit      = 1'b0;
		emit_err  = 1'b0;
		lc_emit   = lc_q;
		if (end_of_input) begin
			if (phase_q == PH_COMMENT || phase_q == PH_AFTER_MODE ||
			    (phase_q == PH_FIELDS && (dc_q != '0 || fc_q != '0))) begin
				emit     = 1'b1;
				emit_err = 1'b1;
			end
			phase_nxt = PH_START;
			lc_nxt    = '0;
			mode_nxt  = 1'b0;
			dv_nxt    = '0;
			ov_nxt    = 1'b0;
			dc_nxt    = '0;
			lz_nxt    = 1'b0;
			fc_nxt    = '0;
		end else begin
			case (phase_q)
				PH_START: begin
					if (lc_q != '1)
						lc_nxt = lc_q + LINE_BITS'(1);
					lc_emit  = lc_nxt;
					mode_nxt = 1'b0;
					dv_nxt   = '0;
					ov_nxt   = 1'b0;
					dc_nxt   = '0;
					lz_nxt   = 1'b0;
					fc_nxt   = '0;
					if (byte_in == CH_HASH) begin
						phase_nxt = PH_COMMENT;
					end else if (byte_in == CH_LF) begin
						phase_nxt = PH_START;
					end else if (byte_in == CH_B || byte_in == CH_I) begin
						mode_nxt  = (byte_in == CH_I);
						phase_nxt = PH_AFTER_MODE;
					end else begin
						emit      = 1'b1;
						emit_err  = 1'b1;
						phase_nxt = PH_SKIP;
					end
				end
				PH_COMMENT, PH_SKIP: begin
					if (byte_in == CH_LF)
						phase_nxt = PH_START;
				end
				PH_AFTER_MODE: begin
					if (is_space) begin
						phase_nxt = PH_FIELDS;
					end else begin
						emit      = 1'b1;
						emit_err  = 1'b1;
						phase_nxt = (byte_in == CH_LF) ? PH_START : PH_SKIP;
					end
				end
				PH_FIELDS: begin
					if (byte_in == CH_LF) begin
						emit      = 1'b1;
						emit_err  = !((dc_q == '0 || close_ok) &&
						              fc_closed == FC_W'(FIELD_COUNT));
						phase_nxt = PH_START;
					end else if (is_digit) begin
						if (dc_q >= DC_W'(MAX_DIGITS) || fc_q >= FC_W'(FIELD_COUNT)) begin
							emit      = 1'b1;
							emit_err  = 1'b1;
							phase_nxt = PH_SKIP;
						end else begin
							if (dc_q == '0)
								lz_nxt = (byte_in == CH_ZERO);
							dv_nxt = acc[FIELD_W-1:0];
							ov_nxt = acc_over;
							dc_nxt = dc_q + DC_W'(1);
						end
					end else if (is_space) begin
						if (dc_q != '0) begin
							if (close_ok) begin
								store_wr = 1'b1;
								fc_nxt   = fc_q + FC_W'(1);
								dv_nxt   = '0;
								ov_nxt   = 1'b0;
								dc_nxt   = '0;
								lz_nxt   = 1'b0;
							end else begin
								emit      = 1'b1;
								emit_err  = 1'b1;
								phase_nxt = PH_SKIP;
							end
						end
					end else begin
						emit      = 1'b1;
						emit_err  = 1'b1;
						phase_nxt = PH_SKIP;
					end
				end
				default: begin
					phase_nxt = PH_START;
				end
			endcase
		end
	end

	// Record fields: the field closed by the newline comes straight from the accumulator
	genvar k;
	generate
		for (k = 0; k < OUT_FIELDS; k++) begin : g_fld
			if (k < FIELD_COUNT) begin : g_used
				assign rec_fld[k] = (dc_q != '0 && fc_q == FC_W'(k)) ? dv_q : store_q[k];
			end else begin : g_unused
				assign rec_fld[k] = '0;
			end
		end
		for (k = 0; k < FIELD_COUNT; k++) begin : g_store
			always_ff @(posedge clk) begin
				if (item_valid && store_wr && fc_q == FC_W'(k))
					store_q[k] <= dv_q;
			end
		end
	endgenerate

	// Result assembly
	assign lc_wide  = 64'(lc_emit);
	assign res_emit = item_valid && emit;
	always_comb begin
		res.kind = emit_err ? KIND_ERROR : KIND_RECORD;
		res.mode = emit_err ? 1'b0 : mode_q;
		res.fld  = emit_err ? '0 : rec_fld;
		res.line = lc_wide[FIELD_W-1:0];
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			lc_q    <= '0;
			mode_q  <= 1'b0;
			dv_q    <= '0;
			ov_q    <= 1'b0;
			dc_q    <= '0;
			lz_q    <= 1'b0;
			fc_q    <= '0;
		end else if (item_valid) begin
			phase_q <= phase_nxt;
			lc_q    <= lc_nxt;
			mode_q  <= mode_nxt;
			dv_q    <= dv_nxt;
			ov_q    <= ov_nxt;
			dc_q    <= dc_nxt;
			lz_q    <= lz_nxt;
			fc_q    <= fc_nxt;
		end
	end

	`include "mode_line_decimal_field_parser_top_assert.svh"

	// Field count never passes the configured number of fields
	`MLDFP_ASSERT_ALWAYS(a_fc_range, clk, !arst_n || fc_q <= FC_W'(FIELD_COUNT))
	// A record only comes from a newline on a mode line
	`MLDFP_ASSERT(a_rec_on_lf, clk, arst_n, (res_emit && res.kind == KIND_RECORD) |-> (byte_in == CH_LF && !end_of_input && phase_q == PH_FIELDS))
	// Starting a line always leaves a nonzero line count
	`MLDFP_ASSERT(a_line_counted, clk, arst_n, (item_valid && !end_of_input && phase_q == PH_START) |=> (lc_q != '0))

endmodule

FILE: sv/mode_line_decimal_field_parser_top.sv
// Top level of the mode-line parser: input register, parser, result register.
// Takes one text byte per transfer and sustains one byte per clock while the
// master side keeps up: each byte is registered in the input register, goes
// through the parser state update (a times-ten accumulate and a few compares),
// and any record or error lands in the result register, which drives the master
// side. A result is produced only by a newline that ends a mode line, by a
// malformed line, or by an end-of-input mark inside an unfinished comment or mode
// line; all other bytes produce nothing. The input side stalls while a byte is
// held in the input register, a result waits in the output register and the
// master side is not ready, whether or not the held byte would produce another.
module mode_line_decimal_field_parser_top #(
	parameter int FIELD_COUNT = 4,
	parameter int MAX_DIGITS  = 10,
	parameter int LINE_BITS   = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] byte_in
	input  logic [0:0]   s_tuser,   // [0] end_of_input
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [167:0] m_tdata,   // [0] mode_letter, [32:1] first_field,
	                                // [64:33] second_field, [96:65] third_field,
	                                // [128:97] fourth_field, [160:129] line_number,
	                                // [167:161] zero
	output logic [0:0]   m_tuser    // [0] result_kind
);
	import mldfp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eoi_s1;
	logic       adv;
	logic       res_emit;
	rec_t       res;
	logic       out_valid_q;
	rec_t       out_q;

	// Registered byte moves on when the result register can take its outcome
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eoi_s1  <= s_tuser[0];
		end
	end

	mldfp_parser #(
		.FIELD_COUNT(FIELD_COUNT),
		.MAX_DIGITS (MAX_DIGITS),
		.LINE_BITS  (LINE_BITS)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (adv),
		.byte_in     (byte_s1),
		.end_of_input(eoi_s1),
		.res_emit    (res_emit),
		.res         (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= res_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (res_emit)
			out_q <= res;
	end

	// Master-side packing
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tdata  = {7'd0, out_q.line, out_q.fld[3], out_q.fld[2], out_q.fld[1],
	                   out_q.fld[0], out_q.mode};

	`include "mode_line_decimal_field_parser_top_assert.svh"

	// A byte held in the input register is not dropped while the result side stalls
	`MLDFP_ASSERT(a_s1_hold, clk, arst_n, (valid_s1 && out_valid_q && !m_tready) |=> (valid_s1 && $stable(byte_s1) && $stable(eoi_s1)))
	// A new result is only produced when the result register is free or draining
	`MLDFP_ASSERT(a_no_overwrite, clk, arst_n, res_emit |-> (!out_valid_q || m_tready))

endmodule
